>>> rtl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection core.
// No dependencies.
package rti_pkg;

  localparam int DIST_W  = 31;
  localparam int AXES    = 3;
  localparam int LANES   = 3;
  localparam int LANE_U  = 0;
  localparam int LANE_V  = 1;
  localparam int LANE_T  = 2;
  localparam int NUM_DET = 4;
  localparam int DET_D   = 0;
  localparam int DET_U   = 1;
  localparam int DET_V   = 2;
  localparam int DET_T   = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X    = 3'd0,
    REG_ORG_Y    = 3'd1,
    REG_ORG_Z    = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_MAX_DIST = 3'd6
  } cfg_reg_t;

  // sideband that travels with the divider lanes
  typedef struct packed {
    logic             dpos;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
  } div_tag_t;

endpackage

>>> rtl/ray_triangle_intersect_core.sv
// Ray/triangle intersection core: front-face test of streamed triangles against one ray.
// Depends on rti_pkg, rti_det, rti_div.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | in_vert0_x .. in_vert2_z
//   out     | out_valid / out_ready | out_hit, out_distance, out_hit_vec_x/y/z
//   cfg     | cfg_wr_en             | cfg_addr, cfg_wdata
//
// One triangle per cycle while the skid entry is empty. Stages: edge
// stage, five determinant stages, divider setup, one divider stage per
// quotient bit of t, check/multiply stage, output register.
// Synchronous active-low reset clears valid bits, zeroes ray origin and direction, sets max distance to all ones.
// A one-entry skid behind the output register stalls the whole pipe when full.
module ray_triangle_intersect_core import rti_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vert0_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert0_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert0_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert1_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert1_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert1_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert2_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert2_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert2_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [DIST_W-1:0]             out_distance,
  output logic signed [COORD_WIDTH-1:0] out_hit_vec_x,
  output logic signed [COORD_WIDTH-1:0] out_hit_vec_y,
  output logic signed [COORD_WIDTH-1:0] out_hit_vec_z,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_addr,
  input  logic [((COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W)-1:0] cfg_wdata
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;
  localparam int DW  = 3 * W + 4;
  localparam int K   = DIST_W;
  localparam int NW  = DW + FRAC_BITS;
  localparam int XW  = NW + K;
  localparam int NV  = 8 + K;
  localparam int PRW = W + K + 1;
  localparam logic [K-1:0] ONE = {{(K-1){1'b0}}, 1'b1} << FRAC_BITS;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] tdist;
    logic [AXES*W-1:0] vec;
  } res_t;

  logic signed [W-1:0]  org_r [AXES];
  logic signed [W-1:0]  dir_r [AXES];
  logic [DIST_W-1:0]    maxd_r;

  logic                 adv;
  logic [NV-1:0]        vld_r;
  logic signed [W-1:0]  v0 [AXES];
  logic signed [W-1:0]  v1 [AXES];
  logic signed [W-1:0]  v2 [AXES];
  logic signed [EW-1:0] e1_nxt [AXES];
  logic signed [EW-1:0] e2_nxt [AXES];
  logic signed [EW-1:0] sv_nxt [AXES];
  logic signed [EW-1:0] md_nxt [AXES];
  logic signed [EW-1:0] e1_r [AXES];
  logic signed [EW-1:0] e2_r [AXES];
  logic signed [EW-1:0] sv_r [AXES];
  logic signed [EW-1:0] md_r [AXES];
  logic signed [DW-1:0] det [NUM_DET];

  logic [DW-1:0]        num;
  logic [DW-1:0]        mag;
  logic [NW-1:0]        nval;
  logic [XW-1:0]        dlim;
  logic [NW-1:0]        rem_nxt [LANES];
  logic [DW-1:0]        den_nxt;
  div_tag_t             tag_nxt;
  logic [NW-1:0]        rem_r [LANES];
  logic [DW-1:0]        den_r;
  div_tag_t             tag_r;
  logic [K-1:0]         quo [LANES];
  div_tag_t             qtag;

  logic [K-1:0]         qval [LANES];
  logic [LANES-1:0]     lane_ok;
  logic                 hit_nxt;
  logic [K-1:0]         t_nxt;
  logic signed [PRW-1:0] prod_nxt [AXES];
  logic                 hit_r;
  logic [K-1:0]         t_r;
  logic signed [PRW-1:0] prod_r [AXES];

  logic [PRW-1:0]       pmag;
  logic [PRW-1:0]       psh;
  logic [PRW-1:0]       plim;
  logic [PRW-1:0]       psat;
  res_t                 res;
  res_t                 out_r;
  res_t                 skid_r;
  logic                 out_vld_r;
  logic                 skid_vld_r;
  logic                 pipe_out;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        org_r[a] <= '0;
        dir_r[a] <= '0;
      end
      maxd_r <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ORG_X:    org_r[0] <= cfg_wdata[W-1:0];
        REG_ORG_Y:    org_r[1] <= cfg_wdata[W-1:0];
        REG_ORG_Z:    org_r[2] <= cfg_wdata[W-1:0];
        REG_DIR_X:    dir_r[0] <= cfg_wdata[W-1:0];
        REG_DIR_Y:    dir_r[1] <= cfg_wdata[W-1:0];
        REG_DIR_Z:    dir_r[2] <= cfg_wdata[W-1:0];
        REG_MAX_DIST: maxd_r   <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !skid_vld_r;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  // edges and offsets
  always_comb begin
    v0[0] = in_vert0_x;
    v0[1] = in_vert0_y;
    v0[2] = in_vert0_z;
    v1[0] = in_vert1_x;
    v1[1] = in_vert1_y;
    v1[2] = in_vert1_z;
    v2[0] = in_vert2_x;
    v2[1] = in_vert2_y;
    v2[2] = in_vert2_z;
    for (int a = 0; a < AXES; a++) begin
      e1_nxt[a] = EW'(v1[a]) - EW'(v0[a]);
      e2_nxt[a] = EW'(v2[a]) - EW'(v0[a]);
      sv_nxt[a] = EW'(org_r[a]) - EW'(v0[a]);
      md_nxt[a] = -EW'(dir_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      sv_r <= sv_nxt;
      md_r <= md_nxt;
    end
  end

  rti_det #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_det (
    .clk (clk),
    .en  (adv),
    .e1  (e1_r),
    .e2  (e2_r),
    .sv  (sv_r),
    .md  (md_r),
    .det (det)
  );

  // divider setup: magnitudes scaled by 2^F, overflow when quotient >= 2^K
  always_comb begin
    den_nxt      = det[DET_D];
    tag_nxt.dpos = !det[DET_D][DW-1] && (det[DET_D] != '0);
    dlim         = XW'({den_nxt, {K{1'b0}}});
    num          = '0;
    mag          = '0;
    nval         = '0;
    for (int l = 0; l < LANES; l++) begin
      num             = det[DET_U + l];
      tag_nxt.neg[l]  = num[DW-1];
      mag             = num[DW-1] ? (~num + 1'b1) : num;
      nval            = {mag, {FRAC_BITS{1'b0}}};
      tag_nxt.ovf[l]  = XW'(nval) >= dlim;
      rem_nxt[l]      = nval;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      tag_r <= tag_nxt;
    end
  end

  rti_div #(
    .NW (NW),
    .DW (DW),
    .K  (K)
  ) u_div (
    .clk     (clk),
    .en      (adv),
    .rem_in  (rem_r),
    .den_in  (den_r),
    .tag_in  (tag_r),
    .quo_out (quo),
    .tag_out (qtag)
  );

  // range tests; a negative quotient only passes when it truncated to zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_ok[l] = !qtag.ovf[l] && (!qtag.neg[l] || (quo[l] == '0));
      qval[l]    = qtag.neg[l] ? '0 : quo[l];
    end
    hit_nxt = qtag.dpos && (&lane_ok)
              && (qval[LANE_U] <= ONE) && (qval[LANE_V] <= ONE)
              && (({1'b0, qval[LANE_U]} + {1'b0, qval[LANE_V]}) <= {1'b0, ONE})
              && (qval[LANE_T] <= maxd_r);
    t_nxt = hit_nxt ? qval[LANE_T] : '0;
    for (int a = 0; a < AXES; a++) begin
      prod_nxt[a] = dir_r[a] * $signed({1'b0, t_nxt});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= hit_nxt;
      t_r    <= t_nxt;
      prod_r <= prod_nxt;
    end
  end

  // scale back by 2^F toward zero and saturate
  always_comb begin
    res.hit   = hit_r;
    res.tdist = t_r;
    res.vec   = '0;
    pmag      = '0;
    psh       = '0;
    plim      = '0;
    psat      = '0;
    for (int a = 0; a < AXES; a++) begin
      pmag = prod_r[a][PRW-1] ? (~prod_r[a] + 1'b1) : prod_r[a];
      psh  = pmag >> FRAC_BITS;
      plim = prod_r[a][PRW-1] ? (PRW'(1) << (W - 1)) : ((PRW'(1) << (W - 1)) - 1'b1);
      psat = (psh > plim) ? plim : psh;
      res.vec[a*W +: W] = prod_r[a][PRW-1] ? (~psat[W-1:0] + 1'b1) : psat[W-1:0];
    end
  end

  assign pipe_out = vld_r[NV-1] && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (!out_vld_r || out_ready) begin
          out_r      <= skid_r;
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end
      end else if (pipe_out) begin
        if (!out_vld_r || out_ready) begin
          out_r     <= res;
          out_vld_r <= 1'b1;
        end else begin
          skid_r     <= res;
          skid_vld_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_hit       = out_r.hit;
  assign out_distance  = out_r.tdist;
  assign out_hit_vec_x = out_r.vec[0 +: W];
  assign out_hit_vec_y = out_r.vec[W +: W];
  assign out_hit_vec_z = out_r.vec[2*W +: W];

endmodule

>>> rtl/rti_det.sv
// Pipelined 3x3 determinants D, Du, Dv, Dt via shared cross products (5 stages).
// Depends on rti_pkg.
module rti_det import rti_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH:0]   e1 [AXES],
  input  logic signed [COORD_WIDTH:0]   e2 [AXES],
  input  logic signed [COORD_WIDTH:0]   sv [AXES],
  input  logic signed [COORD_WIDTH:0]   md [AXES],
  output logic signed [3*COORD_WIDTH+3:0] det [NUM_DET]
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int DW = 3 * COORD_WIDTH + 4;
  localparam int NX1 [AXES] = '{1, 2, 0};
  localparam int NX2 [AXES] = '{2, 0, 1};

  logic signed [EW-1:0]   xb [3][AXES];
  logic signed [EW-1:0]   xc [3][AXES];
  logic signed [PW-1:0]   prod_nxt [3][AXES][2];
  logic signed [PW-1:0]   prod_r   [3][AXES][2];
  logic signed [EW-1:0]   e1_d1_r [AXES];
  logic signed [EW-1:0]   sv_d1_r [AXES];
  logic signed [EW-1:0]   e1_d2_r [AXES];
  logic signed [EW-1:0]   sv_d2_r [AXES];
  logic signed [PW-1:0]   cr_nxt [3][AXES];
  logic signed [PW-1:0]   cr_r   [3][AXES];
  logic signed [EW-1:0]   da [NUM_DET][AXES];
  logic signed [PW-1:0]   dc [NUM_DET][AXES];
  logic signed [EW-1:0]   hi_op;
  logic signed [EW:0]     lo_op;
  logic signed [2*EW-1:0] ph_nxt [NUM_DET][AXES];
  logic signed [2*EW:0]   pl_nxt [NUM_DET][AXES];
  logic signed [2*EW-1:0] ph_r   [NUM_DET][AXES];
  logic signed [2*EW:0]   pl_r   [NUM_DET][AXES];
  logic signed [DW-1:0]   term_nxt [NUM_DET][AXES];
  logic signed [DW-1:0]   term_r   [NUM_DET][AXES];
  logic signed [DW-1:0]   det_nxt [NUM_DET];
  logic signed [DW-1:0]   det_r   [NUM_DET];

  // crosses: 0 = e2 x md, 1 = s x md, 2 = e2 x s
  always_comb begin
    xb[0] = e2;
    xc[0] = md;
    xb[1] = sv;
    xc[1] = md;
    xb[2] = e2;
    xc[2] = sv;
    for (int x = 0; x < 3; x++) begin
      for (int j = 0; j < AXES; j++) begin
        prod_nxt[x][j][0] = xb[x][NX1[j]] * xc[x][NX2[j]];
        prod_nxt[x][j][1] = xb[x][NX2[j]] * xc[x][NX1[j]];
      end
    end
  end

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      for (int j = 0; j < AXES; j++) begin
        cr_nxt[x][j] = prod_r[x][j][0] - prod_r[x][j][1];
      end
    end
  end

  // D = e1.c0, Du = s.c0, Dv = e1.c1, Dt = e1.c2; cross split in high/low halves
  always_comb begin
    da[DET_D] = e1_d2_r;
    dc[DET_D] = cr_r[0];
    da[DET_U] = sv_d2_r;
    dc[DET_U] = cr_r[0];
    da[DET_V] = e1_d2_r;
    dc[DET_V] = cr_r[1];
    da[DET_T] = e1_d2_r;
    dc[DET_T] = cr_r[2];
    hi_op = '0;
    lo_op = '0;
    for (int k = 0; k < NUM_DET; k++) begin
      for (int j = 0; j < AXES; j++) begin
        hi_op = dc[k][j][PW-1:EW];
        lo_op = $signed({1'b0, dc[k][j][EW-1:0]});
        ph_nxt[k][j] = da[k][j] * hi_op;
        pl_nxt[k][j] = da[k][j] * lo_op;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_DET; k++) begin
      for (int j = 0; j < AXES; j++) begin
        term_nxt[k][j] = (DW'(ph_r[k][j]) <<< EW) + DW'(pl_r[k][j]);
      end
      det_nxt[k] = term_r[k][0] + term_r[k][1] + term_r[k][2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      e1_d1_r <= e1;
      sv_d1_r <= sv;
      cr_r    <= cr_nxt;
      e1_d2_r <= e1_d1_r;
      sv_d2_r <= sv_d1_r;
      ph_r    <= ph_nxt;
      pl_r    <= pl_nxt;
      term_r  <= term_nxt;
      det_r   <= det_nxt;
    end
  end

  assign det = det_r;

endmodule

>>> rtl/rti_div.sv
// Restoring divider, one quotient bit per stage, three lanes sharing one divisor.
// Depends on rti_pkg.
module rti_div import rti_pkg::*; #(
  parameter int NW = 116,
  parameter int DW = 100,
  parameter int K  = 31
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  rem_in [LANES],
  input  logic [DW-1:0]  den_in,
  input  div_tag_t       tag_in,
  output logic [K-1:0]   quo_out [LANES],
  output div_tag_t       tag_out
);

  localparam int XW = NW + K;

  logic [NW-1:0] rem_r [K][LANES];
  logic [K-1:0]  quo_r [K][LANES];
  logic [DW-1:0] den_r [K];
  div_tag_t      tag_r [K];

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic [NW-1:0] rem_s [LANES];
    logic [K-1:0]  quo_s [LANES];
    logic [DW-1:0] den_s;
    div_tag_t      tag_s;
    logic [XW-1:0] dsh;
    logic [NW-1:0] rem_nxt [LANES];
    logic [K-1:0]  quo_nxt [LANES];
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_s = rem_in;
      assign den_s = den_in;
      assign tag_s = tag_in;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          quo_s[l] = '0;
        end
      end
    end else begin : g_next
      assign rem_s = rem_r[j-1];
      assign quo_s = quo_r[j-1];
      assign den_s = den_r[j-1];
      assign tag_s = tag_r[j-1];
    end

    always_comb begin
      dsh = XW'(den_s) << (K - 1 - j);
      ge  = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        ge         = XW'(rem_s[l]) >= dsh;
        rem_nxt[l] = ge ? (rem_s[l] - dsh[NW-1:0]) : rem_s[l];
        quo_nxt[l] = {quo_s[l][K-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        den_r[j] <= den_s;
        tag_r[j] <= tag_s;
      end
    end
  end

  assign quo_out = quo_r[K-1];
  assign tag_out = tag_r[K-1];

endmodule

>>> tb/sv/ray_triangle_intersect_core_tb.sv
`timescale 1ns / 1ps
// Testbench for ray_triangle_intersect_core: streams triangles against several ray
// settings and checks every result against an in-bench Cramer's-rule predictor.
// Depends on rti_pkg and the core RTL.
module ray_triangle_intersect_core_tb;
  import rti_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int ONE = 1 << F;
  localparam int DRAIN = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef logic signed [191:0] wide_t;
  typedef logic [8:0][W-1:0] tri_t;
  typedef struct packed {
    logic hit;
    logic [DIST_W-1:0] tdist;
    logic [2:0][W-1:0] vec;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tri_t tri_bus = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [DIST_W-1:0] out_distance;
  logic [W-1:0] out_vx, out_vy, out_vz;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [W-1:0] cfg_wdata = '0;

  logic signed [W-1:0] ray_org [3];
  logic signed [W-1:0] ray_dir [3];
  logic [DIST_W-1:0] ray_max;

  isect_t expected_isect [$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_triangle_intersect_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vert0_x(tri_bus[0]), .in_vert0_y(tri_bus[1]), .in_vert0_z(tri_bus[2]),
    .in_vert1_x(tri_bus[3]), .in_vert1_y(tri_bus[4]), .in_vert1_z(tri_bus[5]),
    .in_vert2_x(tri_bus[6]), .in_vert2_y(tri_bus[7]), .in_vert2_z(tri_bus[8]),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_distance(out_distance),
    .out_hit_vec_x(out_vx), .out_hit_vec_y(out_vy), .out_hit_vec_z(out_vz),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  function automatic wide_t det3(wide_t a0, wide_t a1, wide_t a2, wide_t b0, wide_t b1,
                                 wide_t b2, wide_t c0, wide_t c1, wide_t c2);
    return a0 * (b1 * c2 - b2 * c1) + a1 * (b2 * c0 - b0 * c2) + a2 * (b0 * c1 - b1 * c0);
  endfunction

  function automatic isect_t predict_isect(tri_t tr);
    wide_t v0 [3], e1 [3], e2 [3], s [3], md [3];
    wide_t d, u, v, t, p, m, lim;
    isect_t r;
    logic neg;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      v0[k] = $signed(tr[k]);
      e1[k] = wide_t'($signed(tr[3+k])) - v0[k];
      e2[k] = wide_t'($signed(tr[6+k])) - v0[k];
      s[k]  = wide_t'(ray_org[k]) - v0[k];
      md[k] = -wide_t'(ray_dir[k]);
    end
    d = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], md[0], md[1], md[2]);
    if (d <= 0) return r;
    u = det3(s[0], s[1], s[2], e2[0], e2[1], e2[2], md[0], md[1], md[2]) * ONE / d;
    if (u < 0 || u > ONE) return r;
    v = det3(e1[0], e1[1], e1[2], s[0], s[1], s[2], md[0], md[1], md[2]) * ONE / d;
    if (v < 0 || v > ONE || u + v > ONE) return r;
    t = det3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], s[0], s[1], s[2]) * ONE / d;
    lim = '0;
    lim[DIST_W-1:0] = ray_max;
    if (t < 0 || t > lim) return r;
    r.hit = 1'b1;
    r.tdist = t[DIST_W-1:0];
    for (int k = 0; k < 3; k++) begin
      p = wide_t'(ray_dir[k]) * t;
      neg = p < 0;
      m = (neg ? -p : p) >>> F;
      lim = neg ? (wide_t'(1) <<< (W - 1)) : (wide_t'(1) <<< (W - 1)) - 1;
      if (m > lim) m = lim;
      p = neg ? -m : m;
      r.vec[k] = p[W-1:0];
    end
    return r;
  endfunction

  // receiver: stall pattern rotates through always ready and three random ready rates
  always @(negedge clk) begin
    case ((cycles >> 6) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(1) == 1);
      2: out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= ($urandom_range(7) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_triangle_intersect_core_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    isect_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = {out_hit, out_distance, out_vz, out_vy, out_vx};
      if (expected_isect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
      end else begin
        exp_r = expected_isect.pop_front();
        if (got.hit !== exp_r.hit || got.tdist !== exp_r.tdist || got.vec[0] !== exp_r.vec[0]
            || got.vec[1] !== exp_r.vec[1] || got.vec[2] !== exp_r.vec[2]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%b t=%h v=%h %h %h, got hit=%b t=%h v=%h %h %h",
                     exp_r.hit, exp_r.tdist, exp_r.vec[0], exp_r.vec[1], exp_r.vec[2],
                     got.hit, got.tdist, got.vec[0], got.vec[1], got.vec[2]);
        end
      end
    end
  end

  task automatic send_tri(tri_t tr);
    isect_t exp_r;
    exp_r = predict_isect(tr);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    tri_bus = tr;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_isect.push_back(exp_r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_isect.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
  endtask

  task automatic set_ray(logic [W-1:0] ox, logic [W-1:0] oy, logic [W-1:0] oz,
                         logic [W-1:0] dx, logic [W-1:0] dy, logic [W-1:0] dz,
                         logic [DIST_W-1:0] maxd);
    wait_idle();
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_MAX_DIST, W'(maxd));
    write_reg(CFG_UNUSED, $urandom);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    ray_org[0] = ox; ray_org[1] = oy; ray_org[2] = oz;
    ray_dir[0] = dx; ray_dir[1] = dy; ray_dir[2] = dz;
    ray_max = maxd;
  endtask

  // triangle built around a point on the ray, facing either way
  function automatic tri_t aimed_tri();
    tri_t tr;
    longint pt, e1, e2, v0, tt;
    int a, b, sc;
    logic flip;
    tt = ($urandom_range(9) == 0) ? longint'($urandom_range(0, 32'h7fffffff))
                                  : longint'($urandom_range(0, 1 << 21));
    sc = $urandom_range(4, 22);
    a = $urandom_range(0, 256);
    b = $urandom_range(0, 256 - a);
    flip = $urandom_range(1);
    for (int k = 0; k < 3; k++) begin
      pt = longint'(ray_org[k]) + ((longint'(ray_dir[k]) * tt) >>> F);
      e1 = longint'($urandom_range(0, 2 << sc)) - (1 << sc);
      e2 = longint'($urandom_range(0, 2 << sc)) - (1 << sc);
      v0 = pt - (a * e1 + b * e2) / 256;
      tr[k] = v0[W-1:0];
      tr[flip ? 6 + k : 3 + k] = W'(v0 + e1);
      tr[flip ? 3 + k : 6 + k] = W'(v0 + e2);
    end
    return tr;
  endfunction

  function automatic tri_t noise_tri();
    tri_t tr;
    int sc;
    sc = $urandom_range(0, 1) ? 31 : $urandom_range(4, 24);
    for (int k = 0; k < 9; k++)
      tr[k] = (sc == 31) ? W'($urandom) : W'(int'($urandom_range(0, 2 << sc)) - (1 << sc));
    return tr;
  endfunction

  task automatic run_mix(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) send_tri(aimed_tri());
      else send_tri(noise_tri());
    end
  endtask

  task automatic test_reset_ray();
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, 0};
    ray_max = '1;
    send_tri({9{32'h0}});
    send_tri({9{32'h7fffffff}});
    send_tri({9{32'h80000000}});
    run_mix(60);
  endtask

  task automatic test_axis_ray();
    set_ray(0, 0, 0, 0, 0, ONE, '1);
    // back face at z = 5, then the same face reversed to face front
    send_tri({32'(5 * ONE), 32'(ONE), 32'(-ONE), 32'(5 * ONE), 32'(-ONE), 32'(ONE),
              32'(5 * ONE), 32'(-ONE), 32'(-ONE)});
    send_tri({32'(5 * ONE), 32'(-ONE), 32'(ONE), 32'(5 * ONE), 32'(ONE), 32'(-ONE),
              32'(5 * ONE), 32'(-ONE), 32'(-ONE)});
    // ray through a vertex of a back face, and behind the origin
    send_tri({32'(2 * ONE), 32'(ONE), 32'(0), 32'(2 * ONE), 32'(0), 32'(ONE),
              32'(2 * ONE), 32'(0), 32'(0)});
    send_tri({32'(-2 * ONE), 32'(ONE), 32'(-ONE), 32'(-2 * ONE), 32'(-ONE), 32'(ONE),
              32'(-2 * ONE), 32'(-ONE), 32'(-ONE)});
    send_tri({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    send_tri({32'h55555555, 32'haaaaaaaa, 32'h0, 32'haaaaaaaa, 32'h55555555, 32'h0,
              32'h0, 32'h80000000, 32'h80000000});
    run_mix(500);
  endtask

  task automatic test_random_ray();
    for (int ph = 0; ph < 4; ph++) begin
      set_ray(int'($urandom_range(0, 1 << 24)) - (1 << 23),
              int'($urandom_range(0, 1 << 24)) - (1 << 23),
              int'($urandom_range(0, 1 << 24)) - (1 << 23),
              int'($urandom_range(0, 1 << 18)) - (1 << 17),
              int'($urandom_range(0, 1 << 18)) - (1 << 17),
              int'($urandom_range(0, 1 << 18)) - (1 << 17),
              DIST_W'($urandom_range(0, 1 << 22)));
      run_mix(180);
    end
  endtask

  task automatic test_extreme_ray();
    set_ray(32'h7fffffff, 32'h80000000, 0, 32'h7fff0000, 32'h80000000, 32'h7fffffff, '1);
    run_mix(150);
    set_ray(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000, 32'h7fffffff,
            32'h80000001, '1);
    run_mix(150);
    set_ray(0, 0, 0, ONE, ONE, ONE, '0);
    run_mix(100);
    set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            DIST_W'($urandom));
    run_mix(100);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_reset_ray();
    test_axis_ray();
    test_random_ray();
    test_extreme_ray();
    wait_idle();
    if (mismatches == 0) begin
      $display("ray_triangle_intersect_core_tb: done, clean");
    end else begin
      $display("ray_triangle_intersect_core_tb: done, errors");
    end
    $finish;
  end

endmodule
